[design/ogr_pkg.sv]
// ----------------------------------------------------------------------------
// ogr_pkg
// Shared types and constants for the occupancy grid rectangle engine.
// ----------------------------------------------------------------------------
package ogr_pkg;

    // Command field widths
    localparam int MODE_W  = 3;
    localparam int POS_W   = 6;
    localparam int SIZE_W  = 7;
    localparam int CODE_W  = 2;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_TEST       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TEST_GROWN = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FILL       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FILL_FRAME = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR_EDGE = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ       = 3'd6;

    // Cell codes
    localparam logic [CODE_W-1:0] CELL_EMPTY    = 2'd0;
    localparam logic [CODE_W-1:0] CELL_OCCUPIED = 2'd1;
    localparam logic [CODE_W-1:0] CELL_BORDER   = 2'd2;

    // Configuration registers
    localparam int               CFG_REG_W       = 7;
    localparam int               APB_ADDR_W      = 3;
    localparam int               APB_DATA_W      = 32;
    localparam logic             REG_GRID_WIDTH  = 1'b0;
    localparam logic             REG_GRID_HEIGHT = 1'b1;
    localparam logic [CFG_REG_W-1:0] GRID_RESET  = 7'd64;

    // Effective grid size holds up to 511
    localparam int GRID_W  = 9;
    // Signed coordinates reach from -1 up to grid bounds plus rectangle extent
    localparam int COORD_W = 10;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [GRID_W-1:0] width;
        logic [GRID_W-1:0] height;
    } t_grid_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

[design/ogr_ifs.sv]
// ----------------------------------------------------------------------------
// ogr_ifs
// Command and result channels of the occupancy grid rectangle engine.
// ----------------------------------------------------------------------------
interface ogr_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [ogr_pkg::MODE_W-1:0]    mode;
    logic [ogr_pkg::POS_W-1:0]     rect_x;
    logic [ogr_pkg::POS_W-1:0]     rect_y;
    logic [ogr_pkg::SIZE_W-1:0]    rect_w;
    logic [ogr_pkg::SIZE_W-1:0]    rect_h;

    modport source (output valid, mode, rect_x, rect_y, rect_w, rect_h, input ready);
    modport sink   (input valid, mode, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface ogr_res_if;
    logic                          valid;
    logic                          ready;
    logic                          occupied;
    logic [ogr_pkg::CODE_W-1:0]    cell_code;
    logic                          out_of_range;

    modport source (output valid, occupied, cell_code, out_of_range, input ready);
    modport sink   (input valid, occupied, cell_code, out_of_range, output ready);
endinterface

[design/ogr_cfg.sv]
// ----------------------------------------------------------------------------
// ogr_cfg
// APB register block for grid size, with clamping to the supported range.
// ----------------------------------------------------------------------------
module ogr_cfg #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ogr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ogr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ogr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output ogr_pkg::t_grid_cfg                o_grid
);
    import ogr_pkg::*;

    logic [CFG_REG_W-1:0] r_grid_width;
    logic [CFG_REG_W-1:0] r_grid_height;
    logic                 wr_access;
    logic [GRID_W-1:0]    width_ext;
    logic [GRID_W-1:0]    height_ext;

    assign pready    = 1'b1;
    assign wr_access = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_RESET;
            r_grid_height <= GRID_RESET;
        end else if (wr_access) begin
            case (paddr[2])
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[CFG_REG_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[CFG_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GRID_WIDTH:  prdata = APB_DATA_W'(r_grid_width);
            REG_GRID_HEIGHT: prdata = APB_DATA_W'(r_grid_height);
            default:         prdata = '0;
        endcase
    end

    // zero acts as one, anything beyond the store acts as the store size
    assign width_ext  = GRID_W'(r_grid_width);
    assign height_ext = GRID_W'(r_grid_height);

    always_comb begin
        if (width_ext == '0)
            o_grid.width = GRID_W'(1);
        else if (width_ext > GRID_W'(MAX_COLUMNS))
            o_grid.width = GRID_W'(MAX_COLUMNS);
        else
            o_grid.width = width_ext;

        if (height_ext == '0)
            o_grid.height = GRID_W'(1);
        else if (height_ext > GRID_W'(MAX_ROWS))
            o_grid.height = GRID_W'(MAX_ROWS);
        else
            o_grid.height = height_ext;
    end

endmodule

[design/ogr_row_mem.sv]
// ----------------------------------------------------------------------------
// ogr_row_mem
// Row-wide cell store: one write port, one registered read port, and a
// valid bit per row so that unwritten rows read as empty after reset.
// ----------------------------------------------------------------------------
module ogr_row_mem #(
    parameter int ROWS   = 64,
    parameter int WORD_W = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(ROWS)-1:0]  i_rd_addr,
    output logic [WORD_W-1:0]        o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(ROWS)-1:0]  i_wr_addr,
    input  logic [WORD_W-1:0]        i_wr_data
);
    logic [WORD_W-1:0] r_mem [ROWS];
    logic [WORD_W-1:0] r_rd_data;
    logic [ROWS-1:0]   r_valid;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

[design/ogr_ctrl.sv]
// ----------------------------------------------------------------------------
// ogr_ctrl
// Command sequencer: sets up row range and column masks, walks the rows
// through reads, writes or read-modify-write, and registers the result.
// ----------------------------------------------------------------------------
module ogr_ctrl #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ogr_cmd_if.sink                        i_cmd,
    ogr_res_if.source                      o_res,
    input  ogr_pkg::t_grid_cfg             i_grid,
    output logic                           o_rd_en,
    output logic [$clog2(MAX_ROWS)-1:0]    o_rd_addr,
    input  logic [2*MAX_COLUMNS-1:0]       i_rd_data,
    output logic                           o_wr_en,
    output logic [$clog2(MAX_ROWS)-1:0]    o_wr_addr,
    output logic [2*MAX_COLUMNS-1:0]       o_wr_data
);
    import ogr_pkg::*;

    localparam int RAW    = $clog2(MAX_ROWS);
    localparam int CAW    = $clog2(MAX_COLUMNS);
    localparam int WORD_W = 2 * MAX_COLUMNS;

    t_state                r_state, n_state;
    logic [MODE_W-1:0]     r_mode;
    t_coord                r_x, r_y, r_w, r_h;
    logic [MAX_COLUMNS-1:0] r_span, n_span;
    logic [MAX_COLUMNS-1:0] r_inner, n_inner;
    t_coord                r_row, r_row_hi;
    t_coord                n_row_lo, n_row_hi;
    logic                  n_oor;
    logic                  r_oor;
    logic                  r_occ;
    logic [CODE_W-1:0]     r_code;
    logic                  r_p_valid;
    t_coord                r_p_row;
    logic                  r_res_valid;
    logic                  r_res_occ;
    logic [CODE_W-1:0]     r_res_code;
    logic                  r_res_oor;

    logic                  is_test, is_fill, is_clear, is_read;
    logic                  walk_issue;
    logic                  load_result;
    logic                  row_inside;
    logic                  row_hit;
    t_coord                gw, gh;
    logic [WORD_W-1:0]     merged_row;
    logic [WORD_W-1:0]     clear_row;

    assign gw = t_coord'(i_grid.width);
    assign gh = t_coord'(i_grid.height);

    assign is_test  = (r_mode == MODE_TEST) || (r_mode == MODE_TEST_GROWN);
    assign is_fill  = (r_mode == MODE_FILL) || (r_mode == MODE_FILL_FRAME);
    assign is_clear = (r_mode == MODE_CLEAR) || (r_mode == MODE_CLEAR_EDGE);
    assign is_read  = (r_mode == MODE_READ);

    // Setup: row range, out-of-range flag and column masks
    always_comb begin
        t_coord g, ys, ye, xs, xe, lo, hi, cc;
        logic   any_cell, rect_oor, in_grid;
        g  = ((r_mode == MODE_TEST_GROWN) || (r_mode == MODE_FILL_FRAME))
             ? t_coord'(1) : t_coord'(0);
        ys = r_y - g;
        ye = r_y + r_h + g;
        xs = r_x - g;
        xe = r_x + r_w + g;
        any_cell = (ye > ys) && (xe > xs);
        rect_oor = any_cell && ((ys < 0) || (ye > gh) || (xs < 0) || (xe > gw));
        lo = (ys < 0) ? t_coord'(0) : ys;
        hi = (ye > gh) ? gh : ye;
        in_grid = (r_x < gw) && (r_y < gh);

        for (int c = 0; c < MAX_COLUMNS; c++) begin
            cc = t_coord'(c);
            n_span[c]  = (cc >= xs) && (cc < xe) && (cc < gw);
            n_inner[c] = (cc >= r_x) && (cc < r_x + r_w);
        end

        case (r_mode)
            MODE_TEST, MODE_TEST_GROWN, MODE_FILL, MODE_FILL_FRAME: begin
                n_row_lo = lo;
                n_row_hi = any_cell ? hi : lo;
                n_oor    = rect_oor;
            end
            MODE_CLEAR, MODE_CLEAR_EDGE: begin
                n_row_lo = t_coord'(0);
                n_row_hi = t_coord'(MAX_ROWS);
                n_oor    = 1'b0;
            end
            MODE_READ: begin
                n_row_lo = r_y;
                n_row_hi = in_grid ? (r_y + t_coord'(1)) : r_y;
                n_oor    = !in_grid;
            end
            default: begin
                n_row_lo = t_coord'(0);
                n_row_hi = t_coord'(0);
                n_oor    = 1'b0;
            end
        endcase
    end

    // Row merge for fills; frame cells outside the inner rectangle are border
    assign row_inside = (r_p_row >= r_y) && (r_p_row < r_y + r_h);

    always_comb begin
        merged_row = i_rd_data;
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            if (r_span[c]) begin
                merged_row[2*c +: 2] = (row_inside && r_inner[c]) ? CELL_OCCUPIED
                                                                   : CELL_BORDER;
            end
        end
    end

    // Clear pattern for the row under the counter
    always_comb begin
        t_coord cc;
        logic   edge_row;
        edge_row  = (r_row == t_coord'(0)) || (r_row == gh - t_coord'(1));
        clear_row = '0;
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            cc = t_coord'(c);
            if ((r_mode == MODE_CLEAR_EDGE) && (r_row < gh) && (cc < gw) &&
                (edge_row || (cc == t_coord'(0)) || (cc == gw - t_coord'(1)))) begin
                clear_row[2*c +: 2] = CELL_BORDER;
            end
        end
    end

    always_comb begin
        row_hit = 1'b0;
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            row_hit = row_hit || (r_span[c] && (i_rd_data[2*c +: 2] != CELL_EMPTY));
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_cmd.valid) n_state = ST_SETUP;
            ST_SETUP: n_state = ST_WALK;
            ST_WALK:  if (!walk_issue && !r_p_valid) n_state = ST_DONE;
            ST_DONE:  if (!r_res_valid || o_res.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_cmd.ready = 1'b0;
        walk_issue  = 1'b0;
        load_result = 1'b0;
        case (r_state)
            ST_IDLE:  i_cmd.ready = 1'b1;
            ST_SETUP: ;
            ST_WALK:  walk_issue  = (r_row < r_row_hi);
            ST_DONE:  load_result = !r_res_valid || o_res.ready;
            default:  ;
        endcase

        o_rd_en   = walk_issue && !is_clear;
        o_rd_addr = r_row[RAW-1:0];
        o_wr_en   = is_clear ? walk_issue : (r_p_valid && is_fill);
        o_wr_addr = is_clear ? r_row[RAW-1:0] : r_p_row[RAW-1:0];
        o_wr_data = is_clear ? clear_row : merged_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_p_valid   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= o_rd_en;
            if (load_result)
                r_res_valid <= 1'b1;
            else if (o_res.ready)
                r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_mode <= i_cmd.mode;
            r_x    <= t_coord'(i_cmd.rect_x);
            r_y    <= t_coord'(i_cmd.rect_y);
            r_w    <= t_coord'(i_cmd.rect_w);
            r_h    <= t_coord'(i_cmd.rect_h);
            r_code <= CELL_EMPTY;
        end
        if (r_state == ST_SETUP) begin
            r_span   <= n_span;
            r_inner  <= n_inner;
            r_row    <= n_row_lo;
            r_row_hi <= n_row_hi;
            r_oor    <= n_oor;
            r_occ    <= n_oor;
        end
        if (walk_issue) begin
            r_row   <= r_row + t_coord'(1);
            r_p_row <= r_row;
        end
        if (r_p_valid) begin
            if (is_test && row_hit)
                r_occ <= 1'b1;
            if (is_read)
                r_code <= i_rd_data[{r_x[CAW-1:0], 1'b0} +: 2];
        end
        if (load_result) begin
            r_res_occ  <= is_test && r_occ;
            r_res_code <= is_read ? r_code : CELL_EMPTY;
            r_res_oor  <= r_oor;
        end
    end

    assign o_res.valid        = r_res_valid;
    assign o_res.occupied     = r_res_occ;
    assign o_res.cell_code    = r_res_code;
    assign o_res.out_of_range = r_res_oor;

    // read and write-back always target different rows
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rd_en && o_wr_en) |-> (o_rd_addr != o_wr_addr))
        else $error("row read and write collide");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (r_state == ST_WALK))
        else $error("read data pending outside row walk");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (is_fill || is_clear))
        else $error("store written by a non-writing command");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && is_clear) |-> !r_oor)
        else $error("clear command flagged out of range");

endmodule

[design/occupancy_grid_rect_engine.sv]
// Sequence: each command passes setup, a walk over the grid rows that the (grown)
//   rectangle covers (test/fill), and the result register; a read walks one row,
//   none outside the grid; clear writes every store row.
// Throughput: one command at a time; the row walk over the single row memory
//   (one read and one write-back per cycle) sets the rate.
// Reset: grid size returns to 64x64; per-row valid bits make the store empty at once.
// ----------------------------------------------------------------------------
// occupancy_grid_rect_engine
// Occupancy grid with rectangle test, fill, clear and cell read commands.
// ----------------------------------------------------------------------------
module occupancy_grid_rect_engine #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ogr_cmd_if.sink                           i_cmd,
    ogr_res_if.source                         o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ogr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ogr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ogr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import ogr_pkg::*;

    localparam int RAW    = $clog2(MAX_ROWS);
    localparam int WORD_W = 2 * MAX_COLUMNS;

    t_grid_cfg          grid;
    logic               rd_en;
    logic [RAW-1:0]     rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic               wr_en;
    logic [RAW-1:0]     wr_addr;
    logic [WORD_W-1:0]  wr_data;

    ogr_cfg #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_grid  (grid)
    );

    ogr_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_res     (o_res),
        .i_grid    (grid),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    ogr_row_mem #(
        .ROWS   (MAX_ROWS),
        .WORD_W (WORD_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the occupancy grid rectangle engine. Commands go in over the
// command channel and register writes over APB. A local grid model predicts
// every result, and each result transaction is checked field by field in
// order. Directed cases cover the grid edges, empty rectangles, frames, clears
// and odd grid sizes. A short random run under a long result hold-off follows,
// then random phases with each side idling in some phases and not in others.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ogr_pkg::*;

    localparam int GRID_COLS     = 64;
    localparam int GRID_ROWS     = 64;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 70;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 190;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } t_rect_cmd;

    typedef struct packed {
        logic              occupied;
        logic [CODE_W-1:0] cell_code;
        logic              out_of_range;
    } t_grid_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ogr_cmd_if cmd_if ();
    ogr_res_if res_if ();

    occupancy_grid_rect_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Grid model, indexed [row][column]
    logic [CODE_W-1:0]    cell_map [GRID_ROWS][GRID_COLS];
    logic [CFG_REG_W-1:0] cfg_cols;
    logic [CFG_REG_W-1:0] cfg_rows;
    t_grid_result         pending_results [$];

    int mismatches  = 0;
    bit src_idle_en = 1'b0;
    bit snk_idle_en = 1'b0;
    int hold_req    = 0;
    int hold_served = 0;
    int stall_left  = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Mostly no gap, some short, a few long
    function automatic int gap_len(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int eff_cols();
        int c;
        c = cfg_cols;
        if (c < 1) c = 1;
        if (c > GRID_COLS) c = GRID_COLS;
        return c;
    endfunction

    function automatic int eff_rows();
        int r;
        r = cfg_rows;
        if (r < 1) r = 1;
        if (r > GRID_ROWS) r = GRID_ROWS;
        return r;
    endfunction

    function automatic bit cell_in_grid(input int x, input int y);
        return x >= 0 && y >= 0 && x < eff_cols() && y < eff_rows();
    endfunction

    // Updates the grid model and returns the expected result
    function automatic t_grid_result apply_rect_cmd(input t_rect_cmd c);
        t_grid_result r;
        int x0, y0, w, h, g, gw, gh, x, y;
        bit in_rect;
        r  = '0;
        x0 = c.x;
        y0 = c.y;
        w  = c.w;
        h  = c.h;
        g  = (c.mode == MODE_TEST_GROWN || c.mode == MODE_FILL_FRAME) ? 1 : 0;
        case (c.mode)
            MODE_TEST, MODE_TEST_GROWN: begin
                for (y = y0 - g; y < y0 + h + g; y++) begin
                    for (x = x0 - g; x < x0 + w + g; x++) begin
                        if (!cell_in_grid(x, y)) begin
                            r.occupied     = 1'b1;
                            r.out_of_range = 1'b1;
                        end else if (cell_map[y][x] != CELL_EMPTY) begin
                            r.occupied = 1'b1;
                        end
                    end
                end
            end
            MODE_FILL, MODE_FILL_FRAME: begin
                for (y = y0 - g; y < y0 + h + g; y++) begin
                    for (x = x0 - g; x < x0 + w + g; x++) begin
                        in_rect = x >= x0 && x < x0 + w && y >= y0 && y < y0 + h;
                        if (!cell_in_grid(x, y)) r.out_of_range = 1'b1;
                        else cell_map[y][x] = in_rect ? CELL_OCCUPIED : CELL_BORDER;
                    end
                end
            end
            MODE_CLEAR, MODE_CLEAR_EDGE: begin
                gw = eff_cols();
                gh = eff_rows();
                for (y = 0; y < GRID_ROWS; y++) begin
                    for (x = 0; x < GRID_COLS; x++) begin
                        if (c.mode == MODE_CLEAR_EDGE && x < gw && y < gh &&
                            (x == 0 || y == 0 || x == gw - 1 || y == gh - 1))
                            cell_map[y][x] = CELL_BORDER;
                        else
                            cell_map[y][x] = CELL_EMPTY;
                    end
                end
            end
            MODE_READ: begin
                if (cell_in_grid(x0, y0)) r.cell_code = cell_map[y0][x0];
                else r.out_of_range = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Result side: ready with random stalls and requested long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (hold_served != hold_req) begin
                hold_served++;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0) begin
                stall_left = gap_len(snk_idle_en);
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_grid_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with no command outstanding");
            end else begin
                want = pending_results.pop_front();
                if (res_if.occupied !== want.occupied)
                    report_mismatch($sformatf("occupied %b, expected %b",
                                              res_if.occupied, want.occupied));
                if (res_if.cell_code !== want.cell_code)
                    report_mismatch($sformatf("cell_code %0d, expected %0d",
                                              res_if.cell_code, want.cell_code));
                if (res_if.out_of_range !== want.out_of_range)
                    report_mismatch($sformatf("out_of_range %b, expected %b",
                                              res_if.out_of_range, want.out_of_range));
            end
        end
    end

    // Called on a clock edge; returns on the edge where the command is taken
    task automatic send_cmd(input logic [MODE_W-1:0] mode, input int x, input int y,
                            input int w, input int h);
        t_rect_cmd c;
        int gap;
        c.mode = mode;
        c.x    = POS_W'(x);
        c.y    = POS_W'(y);
        c.w    = SIZE_W'(w);
        c.h    = SIZE_W'(h);
        gap    = gap_len(src_idle_en);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.mode   <= c.mode;
        cmd_if.rect_x <= c.x;
        cmd_if.rect_y <= c.y;
        cmd_if.rect_w <= c.w;
        cmd_if.rect_h <= c.h;
        do @(posedge i_clk); while (!cmd_if.ready);
        pending_results.push_back(apply_rect_cmd(c));
    endtask

    task automatic wait_results_drained();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic apb_write_check(input logic reg_sel, input logic [CFG_REG_W-1:0] value);
        logic [APB_DATA_W-1:0] junk;
        logic [APB_DATA_W-1:0] got;
        junk    = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {junk[APB_DATA_W-1:CFG_REG_W], value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == REG_GRID_WIDTH) cfg_cols = value;
        else cfg_rows = value;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (got !== APB_DATA_W'(value))
            report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                      reg_sel, got, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(input int cols, input int rows);
        wait_results_drained();
        apb_write_check(REG_GRID_WIDTH, CFG_REG_W'(cols));
        apb_write_check(REG_GRID_HEIGHT, CFG_REG_W'(rows));
    endtask

    function automatic t_rect_cmd random_rect_cmd();
        t_rect_cmd c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 22)      c.mode = MODE_TEST;
        else if (r < 36) c.mode = MODE_TEST_GROWN;
        else if (r < 54) c.mode = MODE_FILL;
        else if (r < 66) c.mode = MODE_FILL_FRAME;
        else if (r < 68) c.mode = MODE_CLEAR;
        else if (r < 70) c.mode = MODE_CLEAR_EDGE;
        else if (r < 97) c.mode = MODE_READ;
        else             c.mode = MODE_UNUSED;
        // mostly inside the grid in use, sometimes anywhere
        if ($urandom_range(0, 3) != 0) begin
            c.x = POS_W'($urandom_range(0, eff_cols() - 1));
            c.y = POS_W'($urandom_range(0, eff_rows() - 1));
        end else begin
            c.x = POS_W'($urandom_range(0, 63));
            c.y = POS_W'($urandom_range(0, 63));
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
            c.w = SIZE_W'($urandom_range(0, 6));
            c.h = SIZE_W'($urandom_range(0, 6));
        end else if (r < 95) begin
            c.w = SIZE_W'($urandom_range(0, 20));
            c.h = SIZE_W'($urandom_range(0, 20));
        end else begin
            c.w = SIZE_W'($urandom_range(0, 64));
            c.h = SIZE_W'($urandom_range(0, 64));
        end
        return c;
    endfunction

    task automatic test_directed_full_grid();
        send_cmd(MODE_READ,        0,  0,  0,  0);
        send_cmd(MODE_TEST,        0,  0, 64, 64);
        send_cmd(MODE_TEST,        5,  5,  0,  0);   // empty rectangle
        send_cmd(MODE_TEST_GROWN,  0,  0,  0,  0);   // reaches row and column -1
        send_cmd(MODE_FILL,       10, 10,  5,  5);
        send_cmd(MODE_TEST,       14, 14,  1,  1);
        send_cmd(MODE_TEST_GROWN, 15, 15,  3,  3);
        send_cmd(MODE_READ,       14, 10,  0,  0);
        send_cmd(MODE_FILL_FRAME,  0,  0,  3,  3);   // frame partly off grid
        send_cmd(MODE_READ,        3,  3,  0,  0);
        send_cmd(MODE_FILL_FRAME, 30, 30,  0,  0);   // frame only, all border
        send_cmd(MODE_READ,       30, 30,  0,  0);
        send_cmd(MODE_FILL,       60, 60, 64, 64);
        send_cmd(MODE_TEST,       63, 63, 64, 64);
        send_cmd(MODE_READ,       63, 63,  0,  0);
        send_cmd(MODE_UNUSED,     63, 63, 64, 64);
        send_cmd(MODE_CLEAR,      42, 21, 64, 64);
        send_cmd(MODE_TEST,        0,  0, 64, 64);
        send_cmd(MODE_CLEAR_EDGE,  0,  0,  0,  0);
        send_cmd(MODE_READ,        0,  0,  0,  0);
        send_cmd(MODE_READ,       63, 63,  0,  0);
        send_cmd(MODE_TEST,        1,  1, 62, 62);
        send_cmd(MODE_TEST_GROWN,  1,  1, 62, 62);
    endtask

    task automatic test_grid_sizes();
        set_grid(0, 0);                              // acts as 1x1
        send_cmd(MODE_CLEAR_EDGE,  0,  0,  0,  0);
        send_cmd(MODE_READ,        0,  0,  0,  0);
        send_cmd(MODE_READ,        1,  0,  0,  0);
        send_cmd(MODE_FILL_FRAME,  0,  0,  1,  1);
        send_cmd(MODE_READ,        0,  0,  0,  0);
        set_grid(127, 100);                          // clamps to 64x64
        send_cmd(MODE_READ,       63, 63,  0,  0);
        send_cmd(MODE_TEST,        0,  0, 64, 64);
        set_grid(17, 5);
        send_cmd(MODE_CLEAR_EDGE,  0,  0,  0,  0);
        send_cmd(MODE_READ,       16,  4,  0,  0);
        send_cmd(MODE_READ,       17,  2,  0,  0);
        send_cmd(MODE_TEST,        1,  1, 15,  3);
        send_cmd(MODE_FILL,       15,  3,  4,  4);
        send_cmd(MODE_CLEAR,       0,  0,  0,  0);
        set_grid(1, 64);
        send_cmd(MODE_TEST_GROWN,  0, 10,  1,  1);
    endtask

    task automatic test_result_hold_off();
        t_rect_cmd c;
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        hold_req++;
        repeat (12) begin
            c = random_rect_cmd();
            send_cmd(c.mode, c.x, c.y, c.w, c.h);
        end
        wait_results_drained();
    endtask

    task automatic test_random_phases();
        int cols_pick [PHASE_COUNT] = '{64, 1, 0, 127, 7, 64, 33, 2};
        int rows_pick [PHASE_COUNT] = '{64, 64, 0, 100, 3, 1, 20, 65};
        t_rect_cmd c;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p >= PHASE_COUNT - 2) set_grid($urandom_range(0, 127), $urandom_range(0, 127));
            else set_grid(cols_pick[p], rows_pick[p]);
            src_idle_en = (p % 3) != 0;
            snk_idle_en = (p % 4) != 1;
            repeat (PHASE_ITEMS) begin
                c = random_rect_cmd();
                send_cmd(c.mode, c.x, c.y, c.w, c.h);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cmd_if.valid  = 1'b0;
        cmd_if.mode   = MODE_TEST;
        cmd_if.rect_x = '0;
        cmd_if.rect_y = '0;
        cmd_if.rect_w = '0;
        cmd_if.rect_h = '0;
        cfg_cols      = GRID_RESET;
        cfg_rows      = GRID_RESET;
        foreach (cell_map[y, x]) cell_map[y][x] = CELL_EMPTY;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_full_grid();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        test_grid_sizes();
        test_result_hold_off();
        test_random_phases();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
